### rtl/core/v3n_pkg.sv
// Package for the 3D vector normalizer: widths, default parameters and helpers.
// No dependencies; used by every module under rtl/core.
package v3n_pkg;
    localparam int unsigned COMP_WIDTH_DEF = 24;
    localparam int unsigned FRAC_BITS_DEF  = 16;

    // Control bits for a pipeline word; not used by the modules under rtl/core.
    typedef struct packed {
        logic valid;
        logic zero;
    } t_ctl;
endpackage

### rtl/core/v3n_sqrt_stage.sv
// One restoring square-root step: takes two bits of the radicand per stage.
// Depends on v3n_pkg.
module v3n_sqrt_stage import v3n_pkg::*; #(
    parameter int unsigned SW = 48,
    parameter int unsigned RW = 24,
    parameter int unsigned STEP = 0
) (
    input  logic [SW-1:0] i_rem,
    input  logic [RW-1:0] i_root,
    output logic [SW-1:0] o_rem,
    output logic [RW-1:0] o_root
);
    localparam int unsigned SH = 2 * (RW - 1 - STEP);
    logic [SW+1:0] trial;
    logic [SW+1:0] rem_w;
    always_comb begin
        // trial = (4*root + 1) << SH, compared against remainder
        trial = (({{(SW+2-RW){1'b0}}, i_root} << 2) | {{(SW+1){1'b0}}, 1'b1}) << SH;
        rem_w = {2'b00, i_rem};
        if (rem_w >= trial) begin
            o_rem  = SW'(rem_w - trial);
            o_root = RW'({i_root, 1'b1});
        end else begin
            o_rem  = i_rem;
            o_root = RW'({i_root, 1'b0});
        end
    end
endmodule

### rtl/core/v3n_div_stage.sv
// One restoring division step; instantiated once per component lane.
// Depends on v3n_pkg.
module v3n_div_stage import v3n_pkg::*; #(
    parameter int unsigned DW = 24
) (
    input  logic [DW:0]   i_rem,
    input  logic          i_bit,
    input  logic [DW-1:0] i_den,
    output logic [DW:0]   o_rem,
    output logic          o_q
);
    logic [DW+1:0] sh;
    always_comb begin
        sh = {i_rem, i_bit};
        if (sh >= {2'b00, i_den}) begin
            o_rem = (DW+1)'(sh - {2'b00, i_den});
            o_q   = 1'b1;
        end else begin
            o_rem = sh[DW:0];
            o_q   = 1'b0;
        end
    end
endmodule

### rtl/core/vector3_normalize.sv
// 3D vector normalizer top level: squares, pipelined root, pipelined divide.
// Depends on v3n_pkg, v3n_sqrt_stage, v3n_div_stage.
//
// Normalizes a signed fixed-point vector (COMP_WIDTH bits, FRAC_BITS
// fraction bits) to unit length: length = floor(sqrt(x^2+y^2+z^2)),
// each output = (c << FRAC_BITS) / length truncated toward zero, as a
// FRAC_BITS+2 bit signed value. A zero vector yields zero components
// with zero_length set. Accepts one word per cycle while the output is
// not stalled. Registers: magnitudes, sum of squares, then one register
// per square-root bit and per quotient bit. A stall on the output
// freezes the whole pipeline; s_axis_tready follows m_axis_tready
// combinationally, so a word held at the output with m_axis_tready low
// holds every stage and the input in the same cycle.
module vector3_normalize import v3n_pkg::*; #(
    parameter int unsigned COMP_WIDTH = COMP_WIDTH_DEF,
    parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // comp_x, comp_y, comp_z from bit 0 up, zero padded
    input  logic [((3*COMP_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // unit_x, unit_y, unit_z, zero_length from bit 0 up, zero padded
    output logic [((3*(FRAC_BITS+2)+1+7)/8)*8-1:0] m_axis_tdata
);
    localparam int unsigned CW = COMP_WIDTH;
    localparam int unsigned OW = FRAC_BITS + 2;
    localparam int unsigned MW = CW;            // magnitude width
    localparam int unsigned SW = 2 * MW + 2;    // sum of three squares
    localparam int unsigned RW = MW + 1;        // root width
    localparam int unsigned NW = MW + FRAC_BITS;// numerator width
    localparam int unsigned TW = ((3*OW+1+7)/8)*8;
    localparam int unsigned SQ = RW;
    localparam int unsigned DV = NW;
    localparam int unsigned NS = 2 + SQ + DV;   // total stages

    // Pipeline advances when the output slot is free or being taken.
    logic w_adv;
    logic [NS-1:0] r_vld;
    assign w_adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_adv;

    // Stage 0: magnitudes and signs.
    logic [MW-1:0] r_mag [3];
    logic [2:0]    r_neg0;
    // Stage 1: squares summed.
    logic [MW-1:0] r_mag1 [3];
    logic [2:0]    r_neg1;
    logic [SW-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 3; k++) begin
                logic [CW-1:0] c;
                c = s_axis_tdata[k*CW +: CW];
                r_neg0[k] <= c[CW-1];
                r_mag[k]  <= c[CW-1] ? MW'(~c + 1'b1) : c;
            end
            r_mag1 <= r_mag;
            r_neg1 <= r_neg0;
            r_sum  <= SW'(r_mag[0] * r_mag[0]) + SW'(r_mag[1] * r_mag[1])
                    + SW'(r_mag[2] * r_mag[2]);
        end
    end

    // Square-root stages, one root bit each.
    logic [SW-1:0] r_srem  [SQ+1];
    logic [RW-1:0] r_sroot [SQ+1];
    logic [MW-1:0] r_smag  [SQ+1][3];
    logic [2:0]    r_sneg  [SQ+1];
    always_comb begin
        r_srem[0]  = r_sum;
        r_sroot[0] = '0;
        r_smag[0]  = r_mag1;
        r_sneg[0]  = r_neg1;
    end
    for (genvar g = 0; g < SQ; g++) begin : g_sq
        logic [SW-1:0] w_rem;
        logic [RW-1:0] w_root;
        logic [SW-1:0] r_rem_q;
        logic [RW-1:0] r_root_q;
        logic [MW-1:0] r_mag_q [3];
        logic [2:0]    r_neg_q;
        v3n_sqrt_stage #(.SW(SW), .RW(RW), .STEP(g)) u_st (
            .i_rem(r_srem[g]), .i_root(r_sroot[g]), .o_rem(w_rem), .o_root(w_root));
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_rem_q  <= w_rem;
                r_root_q <= w_root;
                r_mag_q  <= r_smag[g];
                r_neg_q  <= r_sneg[g];
            end
        end
        always_comb begin
            r_srem[g+1]  = r_rem_q;
            r_sroot[g+1] = r_root_q;
            r_smag[g+1]  = r_mag_q;
            r_sneg[g+1]  = r_neg_q;
        end
    end

    // Divide stages, one quotient bit per lane each.
    logic [RW:0]   r_drem [DV+1][3];
    logic [NW-1:0] r_dnum [DV+1][3];
    logic [RW-1:0] r_dden [DV+1];
    logic [2:0]    r_dneg [DV+1];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            r_drem[0][k] = '0;
            r_dnum[0][k] = {r_smag[SQ][k], {FRAC_BITS{1'b0}}};
        end
        r_dden[0] = r_sroot[SQ];
        r_dneg[0] = r_sneg[SQ];
    end
    for (genvar g = 0; g < DV; g++) begin : g_dv
        logic [RW:0]   w_rem [3];
        logic [2:0]    w_q;
        logic [RW:0]   r_rem_q [3];
        logic [NW-1:0] r_num_q [3];
        logic [RW-1:0] r_den_q;
        logic [2:0]    r_neg_q;
        for (genvar k = 0; k < 3; k++) begin : g_ln
            v3n_div_stage #(.DW(RW)) u_dv (
                .i_rem(r_drem[g][k]), .i_bit(r_dnum[g][k][NW-1]), .i_den(r_dden[g]),
                .o_rem(w_rem[k]), .o_q(w_q[k]));
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                for (int k = 0; k < 3; k++) begin
                    r_rem_q[k] <= w_rem[k];
                    r_num_q[k] <= {r_dnum[g][k][NW-2:0], w_q[k]};
                end
                r_den_q <= r_dden[g];
                r_neg_q <= r_dneg[g];
            end
        end
        always_comb begin
            r_drem[g+1] = r_rem_q;
            r_dnum[g+1] = r_num_q;
            r_dden[g+1] = r_den_q;
            r_dneg[g+1] = r_neg_q;
        end
    end

    // Valid bits travel beside the data; the final stage is the output slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NS-2:0], s_axis_tvalid};
        end
    end
    assign m_axis_tvalid = r_vld[NS-1];

    // Output formatting: sign restore, zero vector check.
    logic          w_zero;
    logic [OW-1:0] w_u [3];
    always_comb begin
        w_zero = (r_dden[DV] == '0);
        for (int k = 0; k < 3; k++) begin
            logic [OW-1:0] q;
            q = OW'(r_dnum[DV][k]);
            w_u[k] = w_zero ? '0 : (r_dneg[DV][k] ? OW'(~q + 1'b1) : q);
        end
        m_axis_tdata = TW'({w_zero, w_u[2], w_u[1], w_u[0]});
    end

`ifndef ASSERT_OFF
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_zero |-> w_u[0] == '0 && w_u[1] == '0 && w_u[2] == '0)
        else $error("zero vector with nonzero output");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output slot");
`endif
endmodule
